### rtl/eio_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Ease-in/out curve package
// Shared types, piece codes and default constants for the curve pipeline.
// ---------------------------------------------------------------------------
package eio_pkg;

  localparam int unsigned TimeBitsDefault = 16;
  localparam int unsigned FracBitsDefault = 16;
  localparam int unsigned DurationReset   = 1000;

  // Which section of the curve a word falls on.
  typedef enum logic [1:0] {
    PieceEaseIn,
    PieceLinear,
    PieceEaseOut,
    PieceClamp
  } piece_e;

  // Control that travels alongside the data through every stage.
  typedef struct packed {
    logic   valid;
    piece_e piece;
  } ctl_t;

endpackage

### rtl/eio_prep.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Curve piece selection
// Two stages: scaled times, then piece choice and the divider operands.
// ---------------------------------------------------------------------------
module eio_prep import eio_pkg::*; #(
  parameter int unsigned TIME_BITS = TimeBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic [TIME_BITS-1:0] elapsed_i,
  input  logic [TIME_BITS-1:0] duration_i,
  output ctl_t                 ctl_o,
  output logic [TIME_BITS+1:0] num_o,
  output logic [TIME_BITS+1:0] den_o
);

  localparam int unsigned DW  = TIME_BITS + 2;
  localparam int unsigned E3W = TIME_BITS + 3;
  localparam int unsigned E4W = TIME_BITS + 4;

  // Stage one: multiples of elapsed and duration.
  logic                 s1_vld_q, s1_clamp_q;
  logic [E4W-1:0]       s1_e10_q, s1_e10_d;
  logic [E3W-1:0]       s1_e6_q, s1_e6_d;
  logic [DW-1:0]        s1_d3_q, s1_d3_d;
  logic [E3W-1:0]       s1_d7_q, s1_d7_d;
  logic [TIME_BITS-1:0] s1_d_q, s1_dme_q, s1_dme_d;

  assign s1_e10_d = (E4W'(elapsed_i) << 3) + (E4W'(elapsed_i) << 1);
  assign s1_e6_d  = (E3W'(elapsed_i) << 2) + (E3W'(elapsed_i) << 1);
  assign s1_d3_d  = (DW'(duration_i) << 1) + DW'(duration_i);
  assign s1_d7_d  = (E3W'(duration_i) << 2) + (E3W'(duration_i) << 1) + E3W'(duration_i);
  assign s1_dme_d = duration_i - elapsed_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_clamp_q <= (elapsed_i >= duration_i);
    s1_e10_q   <= s1_e10_d;
    s1_e6_q    <= s1_e6_d;
    s1_d3_q    <= s1_d3_d;
    s1_d7_q    <= s1_d7_d;
    s1_d_q     <= duration_i;
    s1_dme_q   <= s1_dme_d;
  end

  // Stage two: pick the piece and form numerator and denominator.
  piece_e         piece_d;
  logic [DW-1:0]  num_d, den_d;
  logic [E4W-1:0] dme10;
  logic [E3W-1:0] lin_num;
  ctl_t           ctl_q;
  logic [DW-1:0]  num_q, den_q;

  assign dme10   = (E4W'(s1_dme_q) << 3) + (E4W'(s1_dme_q) << 1);
  assign lin_num = s1_e6_q - E3W'(s1_d_q);

  always_comb begin
    piece_d = PieceClamp;
    num_d   = '0;
    den_d   = s1_d3_q;
    priority if (s1_clamp_q) begin
      piece_d = PieceClamp;
    end else if (s1_e10_q <= E4W'(s1_d3_q)) begin
      piece_d = PieceEaseIn;
      num_d   = DW'(s1_e10_q);
    end else if (s1_e10_q <= E4W'(s1_d7_q)) begin
      piece_d = PieceLinear;
      num_d   = DW'(lin_num);
      den_d   = {s1_d_q, 2'b00};
    end else begin
      piece_d = PieceEaseOut;
      num_d   = DW'(dme10);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q.valid <= s1_vld_q;
      ctl_q.piece <= piece_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
  end

  assign ctl_o = ctl_q;
  assign num_o = num_q;
  assign den_o = den_q;

endmodule

### rtl/eio_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Pipelined fraction divider
// Restoring division, one quotient bit per stage, FRAC_BITS+1 stages.
// ---------------------------------------------------------------------------
module eio_div import eio_pkg::*; #(
  parameter int unsigned TIME_BITS = TimeBitsDefault,
  parameter int unsigned FRAC_BITS = FracBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ctl_t                 ctl_i,
  input  logic [TIME_BITS+1:0] num_i,
  input  logic [TIME_BITS+1:0] den_i,
  output ctl_t                 ctl_o,
  output logic [FRAC_BITS:0]   quo_o
);

  localparam int unsigned DW     = TIME_BITS + 2;
  localparam int unsigned RW     = TIME_BITS + 3;
  localparam int unsigned QW     = FRAC_BITS + 1;
  localparam int unsigned Stages = FRAC_BITS + 1;

  logic [RW-1:0] rem_q [Stages];
  logic [DW-1:0] den_q [Stages];
  logic [QW-1:0] quo_q [Stages];
  ctl_t          ctl_q [Stages];

  for (genvar k = 0; k < Stages; k++) begin : g_stage
    logic [RW-1:0] rem_in, rem_d;
    logic [DW-1:0] den_in;
    logic [QW-1:0] quo_in;
    ctl_t          ctl_in;
    logic          qbit;

    if (k == 0) begin : g_first
      // The integer bit: the numerator never exceeds the denominator.
      assign rem_in = RW'(num_i);
      assign den_in = den_i;
      assign quo_in = '0;
      assign ctl_in = ctl_i;
    end else begin : g_next
      assign rem_in = {rem_q[k-1][RW-2:0], 1'b0};
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
      assign ctl_in = ctl_q[k-1];
    end

    assign qbit  = (rem_in >= RW'(den_in));
    assign rem_d = qbit ? (rem_in - RW'(den_in)) : rem_in;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[k] <= '0;
      end else begin
        ctl_q[k] <= ctl_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k] <= rem_d;
      den_q[k] <= den_in;
      quo_q[k] <= {quo_in[QW-2:0], qbit};
    end
  end

  assign ctl_o = ctl_q[Stages-1];
  assign quo_o = quo_q[Stages-1];

endmodule

### rtl/eio_cube.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Cube, fifth and output select
// Four stages: square, cube, reciprocal multiply by one fifth, final select.
// ---------------------------------------------------------------------------
module eio_cube import eio_pkg::*; #(
  parameter int unsigned FRAC_BITS = FracBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ctl_t               ctl_i,
  input  logic [FRAC_BITS:0] quo_i,
  output logic               valid_o,
  output logic [FRAC_BITS:0] progress_o,
  output logic               saturated_o
);

  localparam int unsigned W  = FRAC_BITS + 1;
  localparam int unsigned W2 = 2 * W;
  // floor(x/5) == (x * ceil(2^K/5)) >> K for every x up to 2^FRAC_BITS.
  localparam int unsigned RecipShift = FRAC_BITS + 3;
  localparam int unsigned RecipC     = ((2 ** RecipShift) + 4) / 5;
  localparam int unsigned FifthW     = W2 - RecipShift;
  localparam logic [W-1:0] OneC      = W'(1) << FRAC_BITS;

  ctl_t           c1_ctl_q, c2_ctl_q, c3_ctl_q, c4_ctl_q;
  logic [W-1:0]   c1_quo_q, c2_quo_q, c3_quo_q;
  logic [W-1:0]   sq_q, cu_q;
  logic [W2-1:0]  sq_full, cu_full, fifth_full, fifth_q;
  logic [FifthW-1:0] fifth;
  logic [W-1:0]   prog_d, prog_q;

  assign sq_full    = W2'(quo_i) * W2'(quo_i);
  assign cu_full    = W2'(sq_q) * W2'(c1_quo_q);
  assign fifth_full = W2'(cu_q) * W2'(RecipC);
  assign fifth      = fifth_q[RecipShift +: FifthW];

  always_comb begin
    unique case (c3_ctl_q.piece)
      PieceEaseIn:  prog_d = W'(fifth);
      PieceLinear:  prog_d = c3_quo_q;
      PieceEaseOut: prog_d = OneC - W'(fifth);
      PieceClamp:   prog_d = OneC;
      default:      prog_d = OneC;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_ctl_q <= '0;
      c2_ctl_q <= '0;
      c3_ctl_q <= '0;
      c4_ctl_q <= '0;
    end else begin
      c1_ctl_q <= ctl_i;
      c2_ctl_q <= c1_ctl_q;
      c3_ctl_q <= c2_ctl_q;
      c4_ctl_q <= c3_ctl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c1_quo_q <= quo_i;
    sq_q     <= sq_full[FRAC_BITS +: W];
    c2_quo_q <= c1_quo_q;
    cu_q     <= cu_full[FRAC_BITS +: W];
    c3_quo_q <= c2_quo_q;
    fifth_q  <= fifth_full;
    prog_q   <= prog_d;
  end

  assign valid_o     = c4_ctl_q.valid;
  assign progress_o  = prog_q;
  assign saturated_o = (c4_ctl_q.piece == PieceClamp);

endmodule

### rtl/ease_in_out_curve_eval.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Ease-in/out progress curve evaluator
// Maps an elapsed tick count to eased progress in unsigned Q1.FRAC_BITS.
// ---------------------------------------------------------------------------
// Usage. A word enters on elapsed_ticks_i at any rising edge where start is
// high and busy is low; busy is never raised, so one word is taken per cycle.
// The result appears on progress_o and saturated_o for exactly one cycle,
// marked by done_o. Results leave in the order the words came in.
// The rate of one word per cycle is set by the fully pipelined divider: it
// produces one quotient bit per stage, so its FRAC_BITS + 1 stages set most
// of the latency, followed by two multiplier stages for the cube, one for
// the reciprocal multiply by one fifth, and a final select register.
// The duration register is loaded through cfg_valid_i/cfg_ready_o with
// cfg_duration_ticks_i; it is always ready. Each word samples the duration
// on entry, so a word already in flight keeps the value it started with.
// Reset clears every stage's valid bit and loads the duration with 1000.
// The receiver cannot stall: done_o is a strobe with no back-pressure.
// An elapsed count at or past the duration yields exactly 1.0 with
// saturated_o set; a zero duration therefore always saturates.
// ---------------------------------------------------------------------------
module ease_in_out_curve_eval import eio_pkg::*; #(
  parameter int unsigned TIME_BITS = TimeBitsDefault,
  parameter int unsigned FRAC_BITS = FracBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Evaluation request
  input  logic                 start,
  output logic                 busy,
  input  logic [TIME_BITS-1:0] elapsed_ticks_i,
  // Result strobe
  output logic                 done_o,
  output logic [FRAC_BITS:0]   progress_o,
  output logic                 saturated_o,
  // Duration register write
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [TIME_BITS-1:0] cfg_duration_ticks_i
);

  localparam int unsigned Latency      = FRAC_BITS + 7;
  localparam logic [FRAC_BITS:0] OneC  = (FRAC_BITS + 1)'(1) << FRAC_BITS;
  localparam logic [TIME_BITS-1:0] DurRst = TIME_BITS'(DurationReset);

  logic [TIME_BITS-1:0] dur_q;
  logic                 accept;
  ctl_t                 prep_ctl, div_ctl;
  logic [TIME_BITS+1:0] num, den;
  logic [FRAC_BITS:0]   quo;

  // No internal hazard ever blocks a new word.
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dur_q <= DurRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      dur_q <= cfg_duration_ticks_i;
    end
  end

  // Scaled times, piece choice and divider operands (two stages).
  eio_prep #(
    .TIME_BITS (TIME_BITS)
  ) u_prep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (accept),
    .elapsed_i  (elapsed_ticks_i),
    .duration_i (dur_q),
    .ctl_o      (prep_ctl),
    .num_o      (num),
    .den_o      (den)
  );

  // Normalised time in Q1.FRAC_BITS, one bit per stage.
  eio_div #(
    .TIME_BITS (TIME_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (prep_ctl),
    .num_i  (num),
    .den_i  (den),
    .ctl_o  (div_ctl),
    .quo_o  (quo)
  );

  // Cubic segments and the final select into the output register.
  eio_cube #(
    .FRAC_BITS (FRAC_BITS)
  ) u_cube (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (div_ctl),
    .quo_i       (quo),
    .valid_o     (done_o),
    .progress_o  (progress_o),
    .saturated_o (saturated_o)
  );

  // Every accepted word comes out after the fixed latency, and nothing else.
  a_word_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##Latency done_o)
    else $error("accepted word did not produce a result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, Latency))
    else $error("result strobe without a matching accepted word");

  a_sat_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && saturated_o) |-> (progress_o == OneC))
    else $error("saturated result is not exactly one");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (progress_o <= OneC))
    else $error("progress above one");

endmodule

### tb/ease_in_out_curve_eval_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Ease-in/out curve evaluator testbench
// Drives elapsed tick words into the curve pipeline under a range of
// durations and checks every result strobe against a predicted curve value.
// ---------------------------------------------------------------------------
module ease_in_out_curve_eval_tb;
  import eio_pkg::*;

  localparam int unsigned TimeBits = TimeBitsDefault;
  localparam int unsigned FracBits = FracBitsDefault;
  // Pipeline depth of the evaluator, plus a little slack.
  localparam int unsigned Latency  = FracBits + 7;
  localparam int unsigned DrainCycles = Latency + 16;
  localparam longint unsigned OneQ = 64'd1 << FracBits;

  // One expected or observed result word.
  typedef struct packed {
    logic [FracBits:0] progress;
    logic              saturated;
  } curve_result_t;

  // Holds its own copy of the duration register, works out the curve value
  // of every accepted word and keeps the results that are still to come.
  class curve_scoreboard;
    logic [TimeBits-1:0] duration;
    curve_result_t       expected_q[$];
    int unsigned         errors;

    function new();
      duration = TimeBits'(DurationReset);
      errors   = 0;
    endfunction

    function void set_duration(logic [TimeBits-1:0] d);
      duration = d;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // The cubic pieces both use a fifth of the truncated cube in Q.F.
    function longint unsigned fifth_cube(longint unsigned x);
      longint unsigned sq;
      longint unsigned cu;
      sq = (x * x) >> FracBits;
      cu = (sq * x) >> FracBits;
      return cu / 5;
    endfunction

    function curve_result_t ease_progress(logic [TimeBits-1:0] elapsed);
      curve_result_t   r;
      longint unsigned e;
      longint unsigned d;
      longint unsigned p;
      e = 64'(elapsed);
      d = 64'(duration);
      r.saturated = 1'b0;
      if (e >= d) begin
        // At or past the end, and always for a zero duration.
        p = OneQ;
        r.saturated = 1'b1;
      end else if (10 * e <= 3 * d) begin
        p = fifth_cube((10 * e * OneQ) / (3 * d));
      end else if (10 * e <= 7 * d) begin
        p = ((6 * e - d) * OneQ) / (4 * d);
      end else begin
        p = OneQ - fifth_cube((10 * (d - e) * OneQ) / (3 * d));
      end
      r.progress = p[FracBits:0];
      return r;
    endfunction

    function void note_word(logic [TimeBits-1:0] elapsed);
      expected_q.push_back(ease_progress(elapsed));
    endfunction

    function void check_result(logic [FracBits:0] progress, logic saturated);
      curve_result_t exp_r;
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing expected: progress %0d saturated %0d",
                 $time, progress, saturated);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (progress !== exp_r.progress) begin
        $display("%0t: progress mismatch: expected %0d, actual %0d",
                 $time, exp_r.progress, progress);
        errors++;
      end
      if (saturated !== exp_r.saturated) begin
        $display("%0t: saturated mismatch: expected %0d, actual %0d",
                 $time, exp_r.saturated, saturated);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic [TimeBits-1:0] elapsed_ticks_i;
  logic                done_o;
  logic [FracBits:0]   progress_o;
  logic                saturated_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [TimeBits-1:0] cfg_duration_ticks_i;

  curve_scoreboard curve_sb = new();

  // Set per phase: when high the sender runs back to back with no gaps.
  bit back_to_back;

  ease_in_out_curve_eval #(
    .TIME_BITS(TimeBits),
    .FRAC_BITS(FracBits)
  ) u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start               (start),
    .busy                (busy),
    .elapsed_ticks_i     (elapsed_ticks_i),
    .done_o              (done_o),
    .progress_o          (progress_o),
    .saturated_o         (saturated_o),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_duration_ticks_i(cfg_duration_ticks_i)
  );

  // The clock runs with an 8 ns period, starting low.
  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Everything that crosses a handshake is sampled at the rising edge, where
  // the inputs are settled (they change at the falling edge) and the outputs
  // still hold the values of the cycle that the edge ends. The result check
  // comes first, although with this latency the order never matters.
  always @(posedge clk_i) begin
    if (done_o === 1'b1) begin
      curve_sb.check_result(progress_o, saturated_o);
    end
    if (start && !busy) begin
      curve_sb.note_word(elapsed_ticks_i);
    end
    if (cfg_valid_i && cfg_ready_o) begin
      curve_sb.set_duration(cfg_duration_ticks_i);
    end
  end

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (back_to_back) return 0;
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Idle cycles put noise on the data port, which the block must ignore.
  task automatic idle_cycles(int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      start           <= 1'b0;
      elapsed_ticks_i <= TimeBits'($urandom_range(0, 65535));
    end
  endtask

  // Offers one word, waits for the rising edge at which it is taken, then idles
  // for a random gap. With no gap, a following call raises start again at the
  // next falling edge, so a run of words keeps start high without lowering it.
  task automatic send_word(logic [TimeBits-1:0] e);
    @(negedge clk_i);
    start           <= 1'b1;
    elapsed_ticks_i <= e;
    do @(posedge clk_i); while (busy);
    idle_cycles(gap_len());
  endtask

  // Drops start, waits for every outstanding result, lets the pipeline
  // empty, and only then loads a new duration, so no word in flight sees
  // the change.
  task automatic load_duration(logic [TimeBits-1:0] d);
    idle_cycles(1);
    while (curve_sb.pending() != 0) @(posedge clk_i);
    idle_cycles(DrainCycles);
    @(negedge clk_i);
    cfg_valid_i          <= 1'b1;
    cfg_duration_ticks_i <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i          <= 1'b0;
    cfg_duration_ticks_i <= TimeBits'($urandom_range(0, 65535));
  endtask

  // A duration for one random phase: the extremes, small values where the
  // pieces are only a few ticks wide, and anything at all.
  function automatic logic [TimeBits-1:0] pick_duration();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 4)  return '0;
    if (r < 14) return TimeBits'($urandom_range(1, 3));
    if (r < 24) return TimeBits'(65535 - $urandom_range(0, 1));
    if (r < 50) return TimeBits'($urandom_range(4, 200));
    return TimeBits'($urandom_range(1, 65535));
  endfunction

  // Elapsed values mostly within the animation, some on the piece
  // boundaries and some spread over the whole field.
  function automatic logic [TimeBits-1:0] pick_elapsed(int unsigned d);
    int unsigned r;
    int          b;
    int unsigned hi;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      hi = d + d / 8 + 1;
      if (hi > 65535) hi = 65535;
      return TimeBits'($urandom_range(0, hi));
    end
    if (r < 85) begin
      case ($urandom_range(0, 2))
        0:       b = int'((3 * d) / 10);
        1:       b = int'((7 * d) / 10);
        default: b = int'(d);
      endcase
      b = b + int'($urandom_range(0, 4)) - 2;
      if (b < 0) b = 0;
      if (b > 65535) b = 65535;
      return TimeBits'(b);
    end
    return TimeBits'($urandom_range(0, 65535));
  endfunction

  initial begin
    int unsigned d;
    rst_ni               = 1'b0;
    start                = 1'b0;
    elapsed_ticks_i      = '0;
    cfg_valid_i          = 1'b0;
    cfg_duration_ticks_i = '0;
    back_to_back         = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    idle_cycles(2);

    // Directed part with the reset duration of 1000: both ends, either side
    // of each piece boundary and the end of the animation, and the two
    // alternating bit patterns.
    send_word(16'd0);
    send_word(16'd1);
    send_word(16'd299);
    send_word(16'd300);
    send_word(16'd301);
    send_word(16'd699);
    send_word(16'd700);
    send_word(16'd701);
    send_word(16'd999);
    send_word(16'd1000);
    send_word(16'd1001);
    send_word(16'h5555);
    send_word(16'hAAAA);
    send_word(16'hFFFF);

    // A zero duration saturates every word, even elapsed time zero.
    load_duration(16'd0);
    send_word(16'd0);
    send_word(16'hFFFF);

    // The longest duration, where the boundaries fall between ticks.
    load_duration(16'd65535);
    send_word(16'd0);
    send_word(16'd19660);
    send_word(16'd19661);
    send_word(16'd45874);
    send_word(16'd45875);
    send_word(16'd65534);
    send_word(16'd65535);

    // The shortest real duration: one tick from start to saturation.
    load_duration(16'd1);
    send_word(16'd0);
    send_word(16'd1);

    // Random part, in phases with a fresh duration each.
    for (int phase = 0; phase < 16; phase++) begin
      d = 32'(pick_duration());
      load_duration(TimeBits'(d));
      back_to_back = ($urandom_range(0, 3) == 0);
      repeat (100) send_word(pick_elapsed(d));
      back_to_back = 1'b0;
    end
    idle_cycles(1);

    while (curve_sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (curve_sb.errors == 0) begin
      $display("ease_in_out_curve_eval_tb: done, clean");
    end else begin
      $display("ease_in_out_curve_eval_tb: done, errors");
    end
    $finish;
  end

  // Far beyond the slowest correct run, which stays below a millisecond.
  initial begin
    #5ms;
    $display("ease_in_out_curve_eval_tb: done, errors");
    $finish;
  end

endmodule
